/* sv/pfa_pkg.sv */
`default_nettype none
package pfa_pkg;

    localparam int FRAME_W  = 36;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 13;
    localparam int SCNT_W   = 17;
    localparam int LCNT_W   = 13;
    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;

    typedef enum logic [1:0] {
        FN_ALLOC_PAGE = 2'd0,
        FN_FREE_PAGE  = 2'd1,
        FN_ALLOC_RUN  = 2'd2,
        FN_FREE_RUN   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOMEM   = 3'd1,
        ST_ZERO    = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_OUTSIDE = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_TAKE,
        S_PUSH,
        S_SRCH_RD,
        S_SRCH_BIT,
        S_RNG_RD,
        S_RNG_MOD,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_CHECK,
        OP_SET,
        OP_CLEAR
    } rng_op_t;

endpackage
`default_nettype wire

/* sv/pfa_stack.sv */
`default_nettype none
module pfa_stack #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic                        clk,
    input  wire logic [ADDR_W-1:0]           addr,
    input  wire logic                        rd_en,
    input  wire logic                        wr_en,
    input  wire logic [pfa_pkg::FRAME_W-1:0] wr_data,
    output logic      [pfa_pkg::FRAME_W-1:0] rd_data
);

    logic [pfa_pkg::FRAME_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule
`default_nettype wire

/* sv/pfa_bitmap.sv */
`default_nettype none
module pfa_bitmap #(
    parameter int WORDS  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [ADDR_W-1:0]          addr,
    input  wire logic                       rd_en,
    input  wire logic                       wr_en,
    input  wire logic [pfa_pkg::WORD_W-1:0] wr_data,
    output logic      [pfa_pkg::WORD_W-1:0] rd_data
);

    logic [pfa_pkg::WORD_W-1:0] mem [WORDS];
    logic [WORDS-1:0]           valid_reg;
    logic                       hit_reg;
    logic [pfa_pkg::WORD_W-1:0] raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_reg <= mem[addr];
            hit_reg <= valid_reg[addr];
        end
    end

    assign rd_data = hit_reg ? raw_reg : '0;

endmodule
`default_nettype wire

/* sv/page_frame_allocator.sv */
// Physical page frame allocator: a LIFO stack of high frames and a free
// bitmap of low frames that hands out contiguous runs.
// Input channel (valid/ready): func, page, run_length. One beat in gives
// exactly one result beat out: frame, status, free_stack_count,
// free_low_count. One item is worked on at a time; in_ready is high only
// while the block is idle.
// A stack pop reads the stack and then takes the frame; a push writes it.
// A low free reads every word of the range to check it, then reads and sets
// each word. A low run search walks the bitmap one bit per cycle plus one
// word read every 64 bits, then reads and clears each word of the run.
// The result sits in an output register; while out_ready is low the block
// still accepts the next beat and works on it, and holds the new result
// until the waiting one is taken.
// Reset empties both pools: stack count zero, every bitmap word marked
// not written (reads as no free frame). No clearing pass is needed.
`default_nettype none
module page_frame_allocator #(
    parameter int STACK_DEPTH = 65536,
    parameter int LOW_PAGES   = 4096,
    parameter int RUN_SEGMENT = 15
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     func,
    input  wire logic [pfa_pkg::FRAME_W-1:0]    page,
    input  wire logic [pfa_pkg::LEN_W-1:0]      run_length,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [pfa_pkg::FRAME_W-1:0]         frame,
    output logic [pfa_pkg::STATUS_W-1:0]        status,
    output logic [pfa_pkg::SCNT_W-1:0]          free_stack_count,
    output logic [pfa_pkg::LCNT_W-1:0]          free_low_count
);

    localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW   = $clog2(STACK_DEPTH + 1);
    localparam int LW    = $clog2(LOW_PAGES + 1);
    localparam int NW    = (LOW_PAGES + pfa_pkg::WORD_W - 1) / pfa_pkg::WORD_W;
    localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int SGW   = $clog2(RUN_SEGMENT);
    localparam int DW    = ((LW > pfa_pkg::LEN_W) ? LW : pfa_pkg::LEN_W) + 1;
    localparam int XW    = ((WAW + pfa_pkg::BIT_W > LW) ? WAW + pfa_pkg::BIT_W : LW) + 1;
    localparam int PSW   = pfa_pkg::FRAME_W + 1;

    pfa_pkg::state_t                state_reg, state_next;
    pfa_pkg::rng_op_t               op_reg, op_next;
    pfa_pkg::status_t               st_reg, st_next;
    logic [pfa_pkg::FRAME_W-1:0]    page_reg, page_next;
    logic [pfa_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [LW-1:0]                  idx_reg, idx_next;
    logic [LW-1:0]                  start_reg, start_next;
    logic [SGW-1:0]                 seg_reg, seg_next;
    logic [LW-1:0]                  first_reg, first_next;
    logic [LW-1:0]                  end_reg, end_next;
    logic [WAW-1:0]                 word_reg, word_next;
    logic [pfa_pkg::FRAME_W-1:0]    res_reg, res_next;
    logic [SCW-1:0]                 scnt_reg, scnt_next;
    logic [LW-1:0]                  lcnt_reg, lcnt_next;
    logic                           ov_reg, ov_next;
    logic [pfa_pkg::FRAME_W-1:0]    oframe_reg, oframe_next;
    logic [pfa_pkg::STATUS_W-1:0]   ostat_reg, ostat_next;
    logic [pfa_pkg::SCNT_W-1:0]     oscnt_reg, oscnt_next;
    logic [pfa_pkg::LCNT_W-1:0]     olcnt_reg, olcnt_next;

    logic [SAW-1:0]                 sk_addr;
    logic                           sk_rd, sk_wr;
    logic [pfa_pkg::FRAME_W-1:0]    sk_rdata;
    logic [WAW-1:0]                 bm_addr;
    logic                           bm_rd, bm_wr;
    logic [pfa_pkg::WORD_W-1:0]     bm_wdata, bm_rdata;

    logic                           accept;
    logic [PSW-1:0]                 run_top;
    logic                           outside;
    logic [DW-1:0]                  gap;
    logic                           bit_free;
    logic [LW-1:0]                  idx_inc;
    logic [LW-1:0]                  end_m1;
    logic [WAW-1:0]                 last_word;
    logic [pfa_pkg::WORD_W-1:0]     mask;
    logic [XW-1:0]                  pos;
    logic                           last_out;

    pfa_stack #(.DEPTH(STACK_DEPTH), .ADDR_W(SAW)) u_stack (
        .clk     (clk),
        .addr    (sk_addr),
        .rd_en   (sk_rd),
        .wr_en   (sk_wr),
        .wr_data (page_reg),
        .rd_data (sk_rdata)
    );

    pfa_bitmap #(.WORDS(NW), .ADDR_W(WAW)) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .addr    (bm_addr),
        .rd_en   (bm_rd),
        .wr_en   (bm_wr),
        .wr_data (bm_wdata),
        .rd_data (bm_rdata)
    );

    assign in_ready         = (state_reg == pfa_pkg::S_IDLE);
    assign accept           = in_valid && in_ready;
    assign out_valid        = ov_reg;
    assign frame            = oframe_reg;
    assign status           = ostat_reg;
    assign free_stack_count = oscnt_reg;
    assign free_low_count   = olcnt_reg;

    assign run_top   = {1'b0, page} + PSW'(run_length);
    assign outside   = ({1'b0, page} >= PSW'(LOW_PAGES)) || (run_top > PSW'(LOW_PAGES));
    assign gap       = DW'(idx_reg) - DW'(start_reg);
    assign bit_free  = bm_rdata[idx_reg[pfa_pkg::BIT_W-1:0]];
    assign idx_inc   = idx_reg + 1'b1;
    assign end_m1    = end_reg - 1'b1;
    assign last_word = WAW'(end_m1 >> pfa_pkg::BIT_W);
    assign last_out  = !ov_reg || out_ready;

    always_comb
    begin
        mask = '0;
        pos  = '0;
        for (int b = 0; b < pfa_pkg::WORD_W; b++)
        begin
            pos = XW'({word_reg, pfa_pkg::BIT_W'(b)});
            mask[b] = (pos >= XW'(first_reg)) && (pos < XW'(end_reg));
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        st_next     = st_reg;
        page_next   = page_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        seg_next    = seg_reg;
        first_next  = first_reg;
        end_next    = end_reg;
        word_next   = word_reg;
        res_next    = res_reg;
        scnt_next   = scnt_reg;
        lcnt_next   = lcnt_reg;
        ov_next     = ov_reg && !out_ready;
        oframe_next = oframe_reg;
        ostat_next  = ostat_reg;
        oscnt_next  = oscnt_reg;
        olcnt_next  = olcnt_reg;

        case (state_reg)
            pfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    page_next  = page;
                    len_next   = run_length;
                    res_next   = '0;
                    st_next    = pfa_pkg::ST_OK;
                    idx_next   = '0;
                    start_next = '0;
                    seg_next   = '0;
                    state_next = pfa_pkg::S_FINISH;
                    case (pfa_pkg::func_t'(func))
                        pfa_pkg::FN_ALLOC_PAGE:
                        begin
                            len_next = pfa_pkg::LEN_W'(1);
                            if (scnt_reg != '0)
                            begin
                                scnt_next  = scnt_reg - 1'b1;
                                state_next = pfa_pkg::S_POP_RD;
                            end
                            else
                            begin
                                state_next = pfa_pkg::S_SRCH_RD;
                            end
                        end
                        pfa_pkg::FN_FREE_PAGE:
                        begin
                            if (page == '0)
                            begin
                                st_next = pfa_pkg::ST_ZERO;
                            end
                            else if (page < pfa_pkg::FRAME_W'(LOW_PAGES))
                            begin
                                len_next   = pfa_pkg::LEN_W'(1);
                                first_next = LW'(page);
                                end_next   = LW'(page) + 1'b1;
                                word_next  = WAW'(LW'(page) >> pfa_pkg::BIT_W);
                                op_next    = pfa_pkg::OP_CHECK;
                                state_next = pfa_pkg::S_RNG_RD;
                            end
                            else if (scnt_reg == SCW'(STACK_DEPTH))
                            begin
                                st_next = pfa_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = pfa_pkg::S_PUSH;
                            end
                        end
                        pfa_pkg::FN_ALLOC_RUN:
                        begin
                            if (run_length == '0)
                            begin
                                st_next = pfa_pkg::ST_NOMEM;
                            end
                            else
                            begin
                                state_next = pfa_pkg::S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            if (outside)
                            begin
                                st_next = pfa_pkg::ST_OUTSIDE;
                            end
                            else if (run_length != '0)
                            begin
                                first_next = LW'(page);
                                end_next   = LW'(run_top);
                                word_next  = WAW'(LW'(page) >> pfa_pkg::BIT_W);
                                op_next    = pfa_pkg::OP_CHECK;
                                state_next = pfa_pkg::S_RNG_RD;
                            end
                        end
                    endcase
                end
            end
            pfa_pkg::S_POP_RD:
            begin
                state_next = pfa_pkg::S_POP_TAKE;
            end
            pfa_pkg::S_POP_TAKE:
            begin
                res_next   = sk_rdata;
                state_next = pfa_pkg::S_FINISH;
            end
            pfa_pkg::S_PUSH:
            begin
                scnt_next  = scnt_reg + 1'b1;
                state_next = pfa_pkg::S_FINISH;
            end
            pfa_pkg::S_SRCH_RD:
            begin
                state_next = pfa_pkg::S_SRCH_BIT;
            end
            pfa_pkg::S_SRCH_BIT:
            begin
                if (gap >= DW'(len_reg))
                begin
                    res_next   = pfa_pkg::FRAME_W'(start_reg);
                    lcnt_next  = lcnt_reg - LW'(len_reg);
                    first_next = start_reg;
                    end_next   = start_reg + LW'(len_reg);
                    word_next  = WAW'(start_reg >> pfa_pkg::BIT_W);
                    op_next    = pfa_pkg::OP_CLEAR;
                    state_next = pfa_pkg::S_RNG_RD;
                end
                else
                begin
                    if (seg_reg == '0)
                    begin
                        start_next = idx_reg;
                    end
                    if (!bit_free)
                    begin
                        start_next = idx_inc;
                    end
                    seg_next = (seg_reg == SGW'(RUN_SEGMENT - 1)) ? '0 : seg_reg + 1'b1;
                    idx_next = idx_inc;
                    if (idx_inc == LW'(LOW_PAGES))
                    begin
                        st_next    = pfa_pkg::ST_NOMEM;
                        state_next = pfa_pkg::S_FINISH;
                    end
                    else if (idx_inc[pfa_pkg::BIT_W-1:0] == '0)
                    begin
                        state_next = pfa_pkg::S_SRCH_RD;
                    end
                end
            end
            pfa_pkg::S_RNG_RD:
            begin
                state_next = pfa_pkg::S_RNG_MOD;
            end
            pfa_pkg::S_RNG_MOD:
            begin
                if (op_reg == pfa_pkg::OP_CHECK && (bm_rdata & mask) != '0)
                begin
                    st_next    = pfa_pkg::ST_DOUBLE;
                    state_next = pfa_pkg::S_FINISH;
                end
                else if (word_reg != last_word)
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = pfa_pkg::S_RNG_RD;
                end
                else if (op_reg == pfa_pkg::OP_CHECK)
                begin
                    op_next    = pfa_pkg::OP_SET;
                    word_next  = WAW'(first_reg >> pfa_pkg::BIT_W);
                    state_next = pfa_pkg::S_RNG_RD;
                end
                else
                begin
                    if (op_reg == pfa_pkg::OP_SET)
                    begin
                        lcnt_next = lcnt_reg + LW'(len_reg);
                    end
                    state_next = pfa_pkg::S_FINISH;
                end
            end
            pfa_pkg::S_FINISH:
            begin
                if (last_out)
                begin
                    ov_next     = 1'b1;
                    oframe_next = (st_reg == pfa_pkg::ST_OK) ? res_reg : '0;
                    ostat_next  = st_reg;
                    oscnt_next  = pfa_pkg::SCNT_W'(scnt_reg);
                    olcnt_next  = pfa_pkg::LCNT_W'(lcnt_reg);
                    state_next  = pfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sk_addr  = SAW'(scnt_reg);
        sk_rd    = 1'b0;
        sk_wr    = 1'b0;
        bm_addr  = word_reg;
        bm_rd    = 1'b0;
        bm_wr    = 1'b0;
        bm_wdata = bm_rdata;
        case (state_reg)
            pfa_pkg::S_POP_RD:
            begin
                sk_rd = 1'b1;
            end
            pfa_pkg::S_PUSH:
            begin
                sk_wr = 1'b1;
            end
            pfa_pkg::S_SRCH_RD:
            begin
                bm_addr = WAW'(idx_reg >> pfa_pkg::BIT_W);
                bm_rd   = 1'b1;
            end
            pfa_pkg::S_RNG_RD:
            begin
                bm_rd = 1'b1;
            end
            pfa_pkg::S_RNG_MOD:
            begin
                case (op_reg)
                    pfa_pkg::OP_SET:
                    begin
                        bm_wr    = 1'b1;
                        bm_wdata = bm_rdata | mask;
                    end
                    pfa_pkg::OP_CLEAR:
                    begin
                        bm_wr    = 1'b1;
                        bm_wdata = bm_rdata & ~mask;
                    end
                    default:
                    begin
                        bm_wr = 1'b0;
                    end
                endcase
            end
            default:
            begin
                sk_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfa_pkg::S_IDLE;
            scnt_reg  <= '0;
            lcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scnt_reg  <= scnt_next;
            lcnt_reg  <= lcnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        st_reg     <= st_next;
        page_reg   <= page_next;
        len_reg    <= len_next;
        idx_reg    <= idx_next;
        start_reg  <= start_next;
        seg_reg    <= seg_next;
        first_reg  <= first_next;
        end_reg    <= end_next;
        word_reg   <= word_next;
        res_reg    <= res_next;
        oframe_reg <= oframe_next;
        ostat_reg  <= ostat_next;
        oscnt_reg  <= oscnt_next;
        olcnt_reg  <= olcnt_next;
    end

endmodule
`default_nettype wire
